// ----- rtl/swmf_pkg.sv -----
// Shared constants and helpers for the sliding window median filter.
// No dependencies; every other file in the block depends on this package.
package swmf_pkg;

  // Width of one sample and of one median word.
  localparam int SAMPLE_W = 16;

  // Default window length.
  localparam int WINDOW_DEFAULT = 5;

  // Floor of the mean of two samples, without a wider intermediate sum.
  function automatic logic [SAMPLE_W-1:0] mean_floor(input logic [SAMPLE_W-1:0] a,
                                                     input logic [SAMPLE_W-1:0] b);
    logic [SAMPLE_W-1:0] lsb;
    lsb = {{(SAMPLE_W-1){1'b0}}, a[0] & b[0]};
    return (a >> 1) + (b >> 1) + lsb;
  endfunction

endpackage

// ----- rtl/swmf_if.sv -----
// Handshake channels for the median filter: one for samples, one for medians.
// Depends on swmf_pkg for the word width.
interface swmf_sample_if;
  logic                          valid;
  logic                          ready;
  logic [swmf_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface swmf_median_if;
  logic                          valid;
  logic                          ready;
  logic [swmf_pkg::SAMPLE_W-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink (input valid, input median, output ready);
endinterface

// ----- rtl/swmf_cell.sv -----
// One cell of the sorted window chain: holds a sample and its age.
// Depends on swmf_pkg; neighbors are wired together in the top level.
module swmf_cell #(
  parameter int WINDOW = swmf_pkg::WINDOW_DEFAULT,
  parameter int AGE_W  = 3,
  parameter int IDX    = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic [swmf_pkg::SAMPLE_W-1:0] x,
  input  logic [swmf_pkg::SAMPLE_W-1:0] up_val,
  input  logic [AGE_W-1:0]              up_age,
  input  logic                          del_below_in,
  input  logic [swmf_pkg::SAMPLE_W-1:0] dn_cval,
  input  logic [AGE_W-1:0]              dn_cage,
  input  logic                          dn_gt,
  output logic [swmf_pkg::SAMPLE_W-1:0] val,
  output logic [AGE_W-1:0]              age,
  output logic [swmf_pkg::SAMPLE_W-1:0] val_next,
  output logic                          del_below_out,
  output logic [swmf_pkg::SAMPLE_W-1:0] cval,
  output logic [AGE_W-1:0]              cage,
  output logic                          cgt
);
  import swmf_pkg::*;

  logic             del;
  logic             shift;
  logic [AGE_W-1:0] age_next;

  // The oldest sample leaves the window on every new word.
  assign del           = (age == AGE_W'(WINDOW - 1));
  assign del_below_out = del_below_in | del;
  assign shift         = del_below_in | del;

  // Compacted view: at or above the leaving sample, take the upper neighbor.
  assign cval = shift ? up_val : val;
  assign cage = shift ? up_age : age;
  assign cgt  = (cval > x);

  // Insert the new sample into the compacted, still sorted, list.
  always_comb begin
    val_next = x;
    age_next = '0;
    if ((IDX > 0) && dn_gt) begin
      val_next = dn_cval;
      age_next = dn_cage + AGE_W'(1);
    end else if ((IDX < WINDOW - 1) && !cgt) begin
      val_next = cval;
      age_next = cage + AGE_W'(1);
    end
  end

  // The window resets to zeros; ages start as a permutation of 0..WINDOW-1.
  always_ff @(posedge clk) begin
    if (rst) begin
      val <= '0;
      age <= AGE_W'(IDX);
    end else if (load) begin
      val <= val_next;
      age <= age_next;
    end
  end

endmodule

// ----- rtl/sliding_window_median_filter_unit.sv -----
// Running median filter over the latest WINDOW 16-bit samples.
// Depends on swmf_pkg, swmf_if and swmf_cell.
//
// The block takes one sample word per clock cycle and returns its median in the
// next cycle, held in an output register. The window lives in a chain of
// WINDOW cells kept in sorted order; each accepted word removes the oldest
// sample and inserts the new one in the same update, so the rate is one word
// per cycle for as long as the median side keeps taking words. The window
// starts as zeros right after reset and needs no clearing pass. For an even
// window the result is the floor of the mean of the two middle samples.
module sliding_window_median_filter_unit #(
  parameter int WINDOW = swmf_pkg::WINDOW_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  swmf_sample_if.sink   sample_ch,
  swmf_median_if.source median_ch
);
  import swmf_pkg::*;

  localparam int AGE_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic                load;
  logic                out_valid;
  logic [SAMPLE_W-1:0] median;
  logic [SAMPLE_W-1:0] median_next;

  logic [SAMPLE_W-1:0] val      [WINDOW];
  logic [AGE_W-1:0]    age      [WINDOW];
  logic [SAMPLE_W-1:0] val_next [WINDOW];
  logic [SAMPLE_W-1:0] cval     [WINDOW];
  logic [AGE_W-1:0]    cage     [WINDOW];
  logic                cgt      [WINDOW];
  logic                del_chain[WINDOW+1];

  // A new word enters whenever the output register is free or being emptied.
  assign sample_ch.ready = !out_valid || median_ch.ready;
  assign load            = sample_ch.valid && sample_ch.ready;

  assign del_chain[0] = 1'b0;

  // Chain of cells, lowest value at index zero.
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic [SAMPLE_W-1:0] up_val;
    logic [AGE_W-1:0]    up_age;
    logic [SAMPLE_W-1:0] dn_cval;
    logic [AGE_W-1:0]    dn_cage;
    logic                dn_gt;

    if (i < WINDOW - 1) begin : g_up
      assign up_val = val[i+1];
      assign up_age = age[i+1];
    end else begin : g_top
      assign up_val = '0;
      assign up_age = '0;
    end

    if (i > 0) begin : g_dn
      assign dn_cval = cval[i-1];
      assign dn_cage = cage[i-1];
      assign dn_gt   = cgt[i-1];
    end else begin : g_bottom
      assign dn_cval = '0;
      assign dn_cage = '0;
      assign dn_gt   = 1'b0;
    end

    swmf_cell #(
      .WINDOW(WINDOW),
      .AGE_W (AGE_W),
      .IDX   (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .load         (load),
      .x            (sample_ch.sample),
      .up_val       (up_val),
      .up_age       (up_age),
      .del_below_in (del_chain[i]),
      .dn_cval      (dn_cval),
      .dn_cage      (dn_cage),
      .dn_gt        (dn_gt),
      .val          (val[i]),
      .age          (age[i]),
      .val_next     (val_next[i]),
      .del_below_out(del_chain[i+1]),
      .cval         (cval[i]),
      .cage         (cage[i]),
      .cgt          (cgt[i])
    );
  end

  // Median of the updated window.
  if ((WINDOW % 2) == 0) begin : g_even
    assign median_next = mean_floor(val_next[WINDOW/2-1], val_next[WINDOW/2]);
  end else begin : g_odd
    assign median_next = val_next[WINDOW/2];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (median_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      median <= median_next;
    end
  end

  assign median_ch.valid  = out_valid;
  assign median_ch.median = median;

endmodule

// ----- rtl/swmf_checker.sv -----
// Port-level checks for the median filter, bound to the top level.
// Depends on swmf_pkg and sliding_window_median_filter_unit.
module swmf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [swmf_pkg::SAMPLE_W-1:0] median
);
  import swmf_pkg::*;

  // Every accepted word yields a median in the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> out_valid)
    else $error("accepted word produced no median");

  // A stalled median blocks new words, so none is overwritten.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while a median was stalled");

  // No median appears without a word accepted before it.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || out_ready) && !(in_valid && in_ready) |=> !out_valid)
    else $error("median appeared without an accepted word");

  // A stalled median holds its value.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(median)))
    else $error("stalled median changed");

endmodule

bind sliding_window_median_filter_unit swmf_checker u_swmf_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (sample_ch.valid),
  .in_ready (sample_ch.ready),
  .out_valid(median_ch.valid),
  .out_ready(median_ch.ready),
  .median   (median_ch.median)
);
